>>> src/bch_parity_encoder_defines.svh
// ----------------------------------------------------------------------------
// BCH parity encoder assertion macros
// Shared property wrappers for the encoder's internal checks.
// ----------------------------------------------------------------------------
`ifndef BCH_PARITY_ENCODER_DEFINES_SVH
`define BCH_PARITY_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BPE_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bch parity encoder: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bch parity encoder: next-cycle check failed");

`endif

>>> src/bpe_pkg.sv
// ----------------------------------------------------------------------------
// BCH parity encoder package
// Payload types, generator constant and the byte-wide division step.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // Remainder geometry: 180 parity bits held left-aligned in 23 bytes
  localparam int REM_BYTES = 23;
  localparam int REM_W     = REM_BYTES * 8;
  localparam int CNT_W     = $clog2(REM_BYTES);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(REM_BYTES - 1);

  // Generator polynomial, low 180 coefficients, x^180 implicit, low nibble zero
  localparam logic [REM_W-1:0] GEN_POLY =
    184'hf3ccca1b16b1f8b1c4a9371685b35d1f0e168d8592b1b0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } msg_item_t;

  typedef struct packed {
    logic [7:0] parity_byte;
    logic       parity_last;
  } par_item_t;

  // Remainder snapshot moving from the front to the queue
  typedef struct packed {
    logic             valid;
    logic [REM_W-1:0] rem;
  } rem_xfer_t;

  // Divide the remainder by the generator over one byte, bit 7 first
  function automatic logic [REM_W-1:0] lfsr_byte(input logic [REM_W-1:0] rem,
                                                 input logic [7:0]       din);
    logic [REM_W-1:0] r;
    logic             fb;
    r = rem;
    for (int b = 7; b >= 0; b--) begin
      fb = din[b] ^ r[REM_W-1];
      r  = {r[REM_W-2:0], 1'b0} ^ (fb ? GEN_POLY : '0);
    end
    return r;
  endfunction

endpackage

>>> src/bpe_front.sv
// ----------------------------------------------------------------------------
// BCH parity encoder front end
// Absorbs message bytes into the remainder and hands it off on the last byte.
// ----------------------------------------------------------------------------
module bpe_front
  import bpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_ready,
  input  msg_item_t msg,
  input  logic      q_full,
  output rem_xfer_t push
);

  logic [REM_W-1:0] remainder;
  logic [REM_W-1:0] remainder_next;
  logic             take;

  // Accept while the queue has room for a finished remainder
  assign msg_ready      = !q_full;
  assign take           = msg_valid && msg_ready;
  assign remainder_next = lfsr_byte(remainder, msg.data_byte);

  // Hand off the finished remainder on the last byte
  assign push.valid = take && msg.last;
  assign push.rem   = remainder_next;

  // Advance the division, clear at message end
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (take) begin
      remainder <= msg.last ? '0 : remainder_next;
    end
  end

endmodule

>>> src/bpe_queue.sv
// ----------------------------------------------------------------------------
// BCH parity encoder remainder queue
// Short FIFO of finished remainders between the front and back ends.
// ----------------------------------------------------------------------------
`include "bch_parity_encoder_defines.svh"

module bpe_queue
  import bpe_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  rem_xfer_t push,
  input  logic      pop,
  output rem_xfer_t head,
  output logic      full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CQ_W  = $clog2(DEPTH + 1);

  logic [REM_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CQ_W-1:0]  count;

  assign full       = (count == CQ_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.rem   = mem[rd_ptr];

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.rem;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push.valid && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push.valid) begin
        count <= count - 1'b1;
      end
    end
  end

  `BPE_ASSERT(a_q_no_overflow, clk, rst, push.valid, !full || pop)
  `BPE_ASSERT(a_q_no_underflow, clk, rst, pop, head.valid)
  `BPE_ASSERT(a_q_bound, clk, rst, 1'b1, count <= CQ_W'(DEPTH))

endmodule

>>> src/bpe_back.sv
// ----------------------------------------------------------------------------
// BCH parity encoder back end
// Serializes one remainder into 23 parity bytes through an output register.
// ----------------------------------------------------------------------------
`include "bch_parity_encoder_defines.svh"

module bpe_back
  import bpe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rem_xfer_t head,
  output logic      pop,
  output logic      par_valid,
  input  logic      par_ready,
  output par_item_t par
);

  logic [REM_W-1:0] shreg;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             advance;
  logic             last_beat;

  // Move a byte into the output register when it is free or being drained
  assign advance   = busy && (!par_valid || par_ready);
  assign last_beat = advance && (cnt == LAST_IDX);
  assign pop       = head.valid && (!busy || last_beat);

  // Busy flag and byte counter, then the shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (last_beat) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (advance) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shreg <= head.rem;
    end else if (advance) begin
      shreg <= {shreg[REM_W-9:0], 8'h00};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      par_valid <= 1'b0;
    end else if (advance) begin
      par_valid <= 1'b1;
    end else if (par_ready) begin
      par_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      par.parity_byte <= shreg[REM_W-1 -: 8];
      par.parity_last <= (cnt == LAST_IDX);
    end
  end

  `BPE_ASSERT_NEXT(a_last_flagged, clk, rst, last_beat, par_valid && par.parity_last)
  `BPE_ASSERT_NEXT(a_mid_unflagged, clk, rst, advance && !last_beat, !par.parity_last)
  `BPE_ASSERT(a_cnt_range, clk, rst, busy, cnt <= LAST_IDX)

endmodule

>>> src/bch_parity_encoder.sv
// ----------------------------------------------------------------------------
// BCH parity encoder
// Systematic BCH encoder, t=12 over GF(2^15), 180 parity bits per message.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload   Item
// msg       msg_valid/msg_ready    msg       message byte, last marks the end
// par       par_valid/par_ready    par       parity byte, 23 per message
//
// One message byte is taken every cycle while ready; eight division steps run
// combinationally. The last byte of a message queues its remainder; the
// serializer sends one parity byte per cycle unless par_ready holds it off.
// msg_ready drops only while the remainder queue (QUEUE_DEPTH entries) is full.
// Synchronous active-high reset clears the remainder, queue and output valid.
// ----------------------------------------------------------------------------
module bch_parity_encoder
  import bpe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      msg_valid,
  output logic      msg_ready,
  input  msg_item_t msg,
  output logic      par_valid,
  input  logic      par_ready,
  output par_item_t par
);

  rem_xfer_t push;
  rem_xfer_t head;
  logic      q_full;
  logic      pop;

  bpe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .q_full    (q_full),
    .push      (push)
  );

  bpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  bpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .par_valid (par_valid),
    .par_ready (par_ready),
    .par       (par)
  );

endmodule
